// ===== design/mbec_pkg.sv =====
// Shared types, constants and fixed-point helpers for the escape-time colorizer.
package mbec_pkg;

  localparam int SCREEN_SIZE = 1024;
  localparam int FRAC_BITS   = 24;
  localparam int ORIGIN_COL  = 400;
  localparam int ORIGIN_ROW  = 300;
  localparam int ESC_RADIUS_SQ = 100;

  localparam int COORD_W = 10;
  localparam int Q_W     = 32;
  localparam int ITER_W  = 10;
  localparam int WIDE_W  = 66;
  localparam int CFG_ADDR_W = 3;

  localparam logic signed [WIDE_W-1:0] ESC_LIMIT =
    WIDE_W'(ESC_RADIUS_SQ) <<< FRAC_BITS;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP_X   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP_Y   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_ITER = 3'd4;

  typedef struct packed {
    logic signed [Q_W-1:0] center_x;
    logic signed [Q_W-1:0] center_y;
    logic signed [Q_W-1:0] step_x;
    logic signed [Q_W-1:0] step_y;
    logic [ITER_W-1:0]     max_iter;
  } cfg_t;

  // Point handed from the front to the iteration engine
  typedef struct packed {
    logic signed [Q_W-1:0] cx;
    logic signed [Q_W-1:0] cy;
    logic [2:0]            lane;
  } point_t;

  typedef struct packed {
    logic                 escaped;
    logic [7:0]           blue;
    logic [7:0]           green;
    logic [7:0]           red;
    logic [ITER_W-1:0]    iter_count;
  } result_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [Q_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v[WIDE_W-1:Q_W-1] == '0 || v[WIDE_W-1:Q_W-1] == '1) begin
      r = v[Q_W-1:0];
    end else if (v[WIDE_W-1]) begin
      r = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(Q_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Fixed-point product rescale: floor shift then saturate
  function automatic logic signed [Q_W-1:0] qscale(input logic signed [2*Q_W-1:0] p);
    logic signed [WIDE_W-1:0] w;
    w = {{(WIDE_W-2*Q_W+FRAC_BITS){p[2*Q_W-1]}}, p[2*Q_W-1:FRAC_BITS]};
    return sat32(w);
  endfunction

  function automatic logic signed [WIDE_W-1:0] ext(input logic signed [Q_W-1:0] v);
    return {{(WIDE_W-Q_W){v[Q_W-1]}}, v};
  endfunction

endpackage

// ===== design/mbec_front.sv =====
// Front end: accepts pixel positions and maps them to complex points.
module mbec_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mbec_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [mbec_pkg::COORD_W-1:0] column_i,
  input  logic [mbec_pkg::COORD_W-1:0] row_i,
  output logic                  push_o,
  output mbec_pkg::point_t      push_data_o,
  input  logic                  full_i
);

  typedef enum logic [1:0] {F_IDLE, F_MULX, F_MULY, F_PUSH} fstate_e;

  localparam int OFF_W  = mbec_pkg::COORD_W + 2;
  localparam int PROD_W = OFF_W + mbec_pkg::Q_W;
  localparam int WW     = mbec_pkg::WIDE_W;

  fstate_e state_q;
  logic [mbec_pkg::COORD_W-1:0] col_q, row_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [mbec_pkg::Q_W-1:0] cx_q, cy;

  logic [mbec_pkg::COORD_W-1:0] col_c, row_c;
  logic signed [OFF_W-1:0] off_x, off_y, off_sel;
  logic signed [mbec_pkg::Q_W-1:0] step_sel;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [WW-1:0] sum_x, sum_y;

  // Positions beyond the screen are pinned to the last line
  always_comb begin
    col_c = ({1'b0, column_i} >= (mbec_pkg::COORD_W+1)'(mbec_pkg::SCREEN_SIZE)) ?
            mbec_pkg::COORD_W'(mbec_pkg::SCREEN_SIZE - 1) : column_i;
    row_c = ({1'b0, row_i} >= (mbec_pkg::COORD_W+1)'(mbec_pkg::SCREEN_SIZE)) ?
            mbec_pkg::COORD_W'(mbec_pkg::SCREEN_SIZE - 1) : row_i;
  end

  // One shared multiplier: real part first, then imaginary
  always_comb begin
    off_x = $signed({2'b00, col_q}) - OFF_W'(mbec_pkg::ORIGIN_COL);
    off_y = $signed({2'b00, row_q}) - OFF_W'(mbec_pkg::ORIGIN_ROW);
    off_sel  = (state_q == F_MULX) ? off_x : off_y;
    step_sel = (state_q == F_MULX) ? cfg_i.step_x : cfg_i.step_y;
    prod_d   = off_sel * step_sel;
    sum_x = {{(WW-PROD_W){prod_q[PROD_W-1]}}, prod_q} + mbec_pkg::ext(cfg_i.center_x);
    sum_y = {{(WW-PROD_W){prod_q[PROD_W-1]}}, prod_q} + mbec_pkg::ext(cfg_i.center_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            col_q   <= col_c;
            row_q   <= row_c;
            state_q <= F_MULX;
          end
        end
        F_MULX: begin
          prod_q  <= prod_d;
          state_q <= F_MULY;
        end
        F_MULY: begin
          cx_q    <= mbec_pkg::sat32(sum_x);
          prod_q  <= prod_d;
          state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (!full_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_comb begin
    cy = mbec_pkg::sat32(sum_y);
  end

  assign in_ready_o       = (state_q == F_IDLE);
  assign push_o           = (state_q == F_PUSH) && !full_i;
  assign push_data_o.cx   = cx_q;
  assign push_data_o.cy   = cy;
  assign push_data_o.lane = col_q[2:0];

endmodule

// ===== design/mbec_fifo.sv =====
// Two-entry point queue between the front end and the iteration engine.
module mbec_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mbec_pkg::point_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output mbec_pkg::point_t pop_data_o,
  output logic             empty_o
);

  mbec_pkg::point_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign full_o     = cnt_q[1];
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

endmodule

// ===== design/mbec_back.sv =====
// Iteration engine: runs the escape loop and holds the colored result item.
module mbec_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mbec_pkg::cfg_t   cfg_i,
  input  logic             empty_i,
  input  mbec_pkg::point_t pop_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mbec_pkg::result_t out_data_o
);

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_UPD, B_DONE} bstate_e;

  localparam int QW = mbec_pkg::Q_W;
  localparam int WW = mbec_pkg::WIDE_W;
  localparam int IW = mbec_pkg::ITER_W;

  bstate_e state_q;
  logic signed [QW-1:0] cx_q, cy_q, zx_q, zy_q;
  logic [2:0]           lane_q;
  logic [IW-1:0]        count_q;
  logic signed [2*QW-1:0] pxx_q, pyy_q, pxy_q;
  logic                 out_valid_q;
  mbec_pkg::result_t    out_q;

  logic signed [QW-1:0] x2, y2, xy;
  logic signed [WW-1:0] mag, nx, ny;
  logic                 out_free;
  logic                 esc;
  logic [2*IW-1:0]      sq;
  logic [IW+2:0]        lane_red;
  mbec_pkg::result_t    res;

  always_comb begin
    x2  = mbec_pkg::qscale(pxx_q);
    y2  = mbec_pkg::qscale(pyy_q);
    xy  = mbec_pkg::qscale(pxy_q);
    mag = mbec_pkg::ext(x2) + mbec_pkg::ext(y2);
    nx  = mbec_pkg::ext(x2) - mbec_pkg::ext(y2) + mbec_pkg::ext(cx_q);
    ny  = {{(WW-QW-1){xy[QW-1]}}, xy, 1'b0} + mbec_pkg::ext(cy_q);
  end

  // Color lookup from the final count, or from the lane for a bounded point
  always_comb begin
    esc      = count_q < cfg_i.max_iter;
    sq       = count_q * count_q;
    lane_red = cfg_i.max_iter * lane_q;
    res.iter_count = count_q;
    res.escaped    = esc;
    if (esc) begin
      res.red   = count_q[7:0];
      res.green = sq[15:8];
      res.blue  = 8'd128 - count_q[7:0];
    end else begin
      res.red   = lane_red[7:0];
      res.green = 8'(lane_q * lane_q);
      res.blue  = {lane_q, 5'b00000};
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == B_IDLE) && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == B_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (!empty_i) begin
            cx_q    <= pop_data_i.cx;
            cy_q    <= pop_data_i.cy;
            zx_q    <= pop_data_i.cx;
            zy_q    <= pop_data_i.cy;
            lane_q  <= pop_data_i.lane;
            count_q <= '0;
            state_q <= B_MUL;
          end
        end
        B_MUL: begin
          if (count_q >= cfg_i.max_iter) begin
            state_q <= B_DONE;
          end else begin
            pxx_q   <= zx_q * zx_q;
            pyy_q   <= zy_q * zy_q;
            pxy_q   <= zx_q * zy_q;
            state_q <= B_UPD;
          end
        end
        B_UPD: begin
          if (mag > mbec_pkg::ESC_LIMIT) begin
            state_q <= B_DONE;
          end else begin
            count_q <= count_q + IW'(1);
            zx_q    <= mbec_pkg::sat32(nx);
            zy_q    <= mbec_pkg::sat32(ny);
            state_q <= B_MUL;
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_q   <= res;
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/mandelbrot_escape_time_colorizer_core.sv =====
// Top level of the escape-time pixel colorizer.
//
// Input stream: one item per pixel, tdata = {row, column}. Output stream: one
// item per input, in order, tdata = {escaped, blue, green, red, iter_count}.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_addr_i
// (0 center_x, 1 center_y, 2 step_x, 3 step_y, 4 iteration limit); write only
// while no pixel is in flight.
// The front end maps a pixel to its point over one shared multiplier and
// parks it in a two-entry queue, so it can take the next pixel while the
// iteration engine is busy. Each counted step of the engine forms the
// products, then rescales them, tests for escape and updates the point; a
// pixel that stays bounded ends with its count equal to the iteration limit.
// Reset empties the queue, drops any result and restores the default view.
// A stalled receiver holds the result register; the engine then waits with
// its next result, the queue fills, and s_axis_tready falls.
module mandelbrot_escape_time_colorizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [9:0] column, [19:10] row, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [9:0] iter_count, [17:10] red,
                                      // [25:18] green, [33:26] blue, [34] escaped
  input  logic        cfg_we_i,
  input  logic [mbec_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [31:0] cfg_data_i
);

  mbec_pkg::cfg_t    cfg_q;
  logic              push, full, pop, empty;
  mbec_pkg::point_t  push_data, pop_data;
  mbec_pkg::result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x <= -32'sd8388608;
      cfg_q.center_y <= 32'sd0;
      cfg_q.step_x   <= 32'sd83886;
      cfg_q.step_y   <= 32'sd83886;
      cfg_q.max_iter <= 10'd256;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        mbec_pkg::CFG_CENTER_X: cfg_q.center_x <= cfg_data_i;
        mbec_pkg::CFG_CENTER_Y: cfg_q.center_y <= cfg_data_i;
        mbec_pkg::CFG_STEP_X:   cfg_q.step_x   <= cfg_data_i;
        mbec_pkg::CFG_STEP_Y:   cfg_q.step_y   <= cfg_data_i;
        mbec_pkg::CFG_MAX_ITER: cfg_q.max_iter <= cfg_data_i[mbec_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  mbec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .column_i    (s_axis_tdata[9:0]),
    .row_i       (s_axis_tdata[19:10]),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  mbec_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  mbec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  assign m_axis_tdata = {5'b00000, res};

endmodule
